@@ rtl/gsfp_pkg.sv @@
`timescale 1ns / 1ps

package gsfp_pkg;

    // Frame layout and marker bytes.
    localparam int unsigned FRAME_LEN      = 9;
    localparam int unsigned POS_W          = 4;
    localparam logic [7:0]  START_BYTE     = 8'hFF;
    localparam logic [7:0]  TYPE_STREAM    = 8'h04;
    localparam logic [7:0]  TYPE_QA        = 8'h86;
    localparam logic [7:0]  FAULT_MASK     = 8'h80;
    localparam logic [7:0]  HIGH_MASK      = 8'h1F;

    localparam logic [POS_W-1:0] POS_START = 4'd0;
    localparam logic [POS_W-1:0] POS_TYPE  = 4'd1;
    localparam logic [POS_W-1:0] POS_B2    = 4'd2;
    localparam logic [POS_W-1:0] POS_B3    = 4'd3;
    localparam logic [POS_W-1:0] POS_B4    = 4'd4;
    localparam logic [POS_W-1:0] POS_B5    = 4'd5;
    localparam logic [POS_W-1:0] POS_CHECK = 4'd8;

    // Field widths.
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CONC_W   = 13;
    localparam int unsigned SEC_W    = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;

    // Input commands.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE_SELECT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_SECONDS = 1'd1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WARMING  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_TYPE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FAULT    = 3'd4;

    // Queue between the collecting front and the judging back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Everything the back needs to judge one completed frame.
    typedef struct packed {
        logic              type_ok;
        logic              elapsed_ok;
        logic              check_ok;
        logic              fault;
        logic [CONC_W-1:0] conc;
    } frame_info_t;

endpackage

@@ rtl/gsfp_front.sv @@
`timescale 1ns / 1ps

module gsfp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic [7:0]                  rx_byte,
    input  logic                        mode_select,
    input  logic [gsfp_pkg::SEC_W-1:0]  warmup_seconds,
    input  logic                        queue_full,
    output logic                        push,
    output gsfp_pkg::frame_info_t       push_data
);
    import gsfp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [SEC_W-1:0] elapsed_reg, elapsed_next;
    logic [7:0]       type_reg;
    logic [7:0]       data_reg [POS_B2:POS_B5];
    logic             accept;
    logic             take_byte;
    logic [7:0]       hi_byte;
    logic [7:0]       lo_byte;
    logic [7:0]       check_sum;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign take_byte = accept && (cmd == CMD_BYTE)
                       && !((pos_reg == POS_START) && (rx_byte != START_BYTE));

    assign hi_byte   = mode_select ? data_reg[POS_B4] : data_reg[POS_B2];
    assign lo_byte   = mode_select ? data_reg[POS_B5] : data_reg[POS_B3];
    assign check_sum = sum_reg + rx_byte;

    assign push = take_byte && (pos_reg == POS_CHECK);

    always_comb
    begin
        push_data.type_ok    = (type_reg == (mode_select ? TYPE_STREAM : TYPE_QA));
        push_data.elapsed_ok = (elapsed_reg >= warmup_seconds);
        push_data.check_ok   = (check_sum == 8'h00);
        push_data.fault      = ((hi_byte & FAULT_MASK) != 8'h00);
        push_data.conc       = {hi_byte[4:0] & HIGH_MASK[4:0], lo_byte};
    end

    always_comb
    begin
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        elapsed_next = elapsed_reg;
        if (accept && (cmd == CMD_TICK) && (elapsed_reg != {SEC_W{1'b1}}))
        begin
            elapsed_next = elapsed_reg + 1'b1;
        end
        if (take_byte)
        begin
            if (pos_reg == POS_CHECK)
            begin
                pos_next = POS_START;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
            if (pos_reg == POS_START)
            begin
                sum_next = 8'h00;
            end
            else if (pos_reg != POS_CHECK)
            begin
                sum_next = sum_reg + rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_START;
            sum_reg     <= 8'h00;
            elapsed_reg <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // Frame bytes are payload: every one is written before it is judged.
    always_ff @(posedge clk)
    begin
        if (take_byte)
        begin
            case (pos_reg)
                POS_TYPE: type_reg         <= rx_byte;
                POS_B2:   data_reg[POS_B2] <= rx_byte;
                POS_B3:   data_reg[POS_B3] <= rx_byte;
                POS_B4:   data_reg[POS_B4] <= rx_byte;
                POS_B5:   data_reg[POS_B5] <= rx_byte;
                default:  ;
            endcase
        end
    end

endmodule

@@ rtl/gsfp_queue.sv @@
`timescale 1ns / 1ps

module gsfp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  gsfp_pkg::frame_info_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output gsfp_pkg::frame_info_t pop_data
);
    import gsfp_pkg::*;

    frame_info_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/gsfp_back.sv @@
`timescale 1ns / 1ps

module gsfp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          queue_not_empty,
    input  gsfp_pkg::frame_info_t         queue_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gsfp_pkg::STATUS_W-1:0] status,
    output logic [gsfp_pkg::CONC_W-1:0]   concentration_tenths
);
    import gsfp_pkg::*;

    logic                valid_reg, valid_next;
    logic                warm_done_reg, warm_done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CONC_W-1:0]   conc_reg, conc_next;

    assign pop = queue_not_empty && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next     = valid_reg;
        warm_done_next = warm_done_reg;
        status_next    = ST_OK;
        conc_next      = '0;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (pop)
        begin
            valid_next = 1'b1;
            if (!queue_data.type_ok)
            begin
                status_next = ST_BAD_TYPE;
            end
            else if (!warm_done_reg && !queue_data.elapsed_ok)
            begin
                status_next = ST_WARMING;
            end
            else
            begin
                // A correctly typed frame past the warm-up time ends warm-up for good.
                warm_done_next = 1'b1;
                if (!queue_data.check_ok)
                begin
                    status_next = ST_CHECKSUM;
                end
                else if (queue_data.fault)
                begin
                    status_next = ST_FAULT;
                end
                else
                begin
                    conc_next = queue_data.conc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            warm_done_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            warm_done_reg <= warm_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            conc_reg   <= conc_next;
        end
    end

    assign out_valid            = valid_reg;
    assign status               = status_reg;
    assign concentration_tenths = conc_reg;

endmodule

@@ rtl/gas_sensor_frame_parser.sv @@
`timescale 1ns / 1ps

// Gas sensor frame parser.
// The input channel (in_valid/in_ready) carries one request per cycle: either
// a received UART byte (cmd low, rx_byte) or a one-second tick (cmd high).
// Bytes are dropped until a 0xFF start byte, then nine bytes make a frame.
// For every completed frame one result request leaves on the output channel
// (out_valid/out_ready) with status and concentration_tenths; ticks and other
// bytes produce nothing. The front collects bytes and condenses each frame
// into a small record, a two-entry queue holds records, and the back judges
// them against the warm-up state and registers the result.
// Input requests keep that rate while the queue is not full. A frame's
// record is written into the queue at the edge that accepts its ninth byte
// and moves into the output register once that register is free. When the
// receiver stalls, the output register holds its result, the queue fills,
// and in_ready falls only once both queue entries are taken. Reset clears
// the frame position, the elapsed-second count and warm-up state, and sets
// stream mode with no warm-up time. The user must write configuration via
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.

module gas_sensor_frame_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            cmd,
    input  logic [7:0]                      rx_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [gsfp_pkg::STATUS_W-1:0]   status,
    output logic [gsfp_pkg::CONC_W-1:0]     concentration_tenths,
    input  logic                            cfg_we,
    input  logic [gsfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gsfp_pkg::CFG_W-1:0]      cfg_data
);
    import gsfp_pkg::*;

    logic             mode_reg, mode_next;
    logic [SEC_W-1:0] warmup_reg, warmup_next;
    logic             push;
    logic             pop;
    logic             queue_full;
    logic             queue_not_empty;
    frame_info_t      push_data;
    frame_info_t      pop_data;

    // Configuration registers; values are masked to their widths.
    always_comb
    begin
        mode_next   = mode_reg;
        warmup_next = warmup_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE_SELECT:    mode_next   = cfg_data[0];
                REG_WARMUP_SECONDS: warmup_next = cfg_data[SEC_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            warmup_reg <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            warmup_reg <= warmup_next;
        end
    end

    gsfp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .rx_byte        (rx_byte),
        .mode_select    (mode_reg),
        .warmup_seconds (warmup_reg),
        .queue_full     (queue_full),
        .push           (push),
        .push_data      (push_data)
    );

    gsfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_data  (pop_data)
    );

    gsfp_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .queue_not_empty      (queue_not_empty),
        .queue_data           (pop_data),
        .pop                  (pop),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .status               (status),
        .concentration_tenths (concentration_tenths)
    );

    // A result that is not good carries no concentration.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (concentration_tenths == '0))
        else $error("concentration reported with a bad status");

    // Only the defined status codes leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_WARMING || status == ST_BAD_TYPE
                       || status == ST_CHECKSUM || status == ST_FAULT))
        else $error("undefined status code");

    // Warming can only be reported when a warm-up time is set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_WARMING)) |-> (warmup_reg != '0))
        else $error("warming reported with no warm-up time");

    // The front never pushes a record into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("frame record pushed into a full queue");

endmodule

@@ verif/gsfp_frame_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the frame parser. It keeps its own view of the
// parser state and queues the reading each completed frame should give. It
// then compares every result request that leaves the block with the oldest
// queued reading.
module gsfp_frame_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            cmd,
    input  logic [7:0]                      rx_byte,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [gsfp_pkg::STATUS_W-1:0]   status,
    input  logic [gsfp_pkg::CONC_W-1:0]     concentration_tenths,
    input  logic                            cfg_we,
    input  logic [gsfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gsfp_pkg::CFG_W-1:0]      cfg_data,
    output logic [31:0]                     mismatch_total,
    output logic [31:0]                     results_outstanding
);
    import gsfp_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CONC_W-1:0]   conc;
    } reading_t;

    logic [7:0]       frame_buf [FRAME_LEN];
    logic [POS_W-1:0] fill_pos;
    logic [SEC_W-1:0] seconds_seen;
    logic             warm_finished;
    logic             stream_mode;
    logic [SEC_W-1:0] warm_limit;
    reading_t         readings_due [$];
    reading_t         want;
    int unsigned      errors;

    // Judges the frame held in frame_buf. Ending the warm-up is a side effect.
    function automatic reading_t assess_frame();
        reading_t   r;
        logic [7:0] want_type;
        logic [7:0] flags;
        logic [7:0] lo;
        logic [7:0] sum;
        int         k;
        r = '0;
        if (stream_mode)
        begin
            want_type = TYPE_STREAM;
            flags     = frame_buf[POS_B4];
            lo        = frame_buf[POS_B5];
        end
        else
        begin
            want_type = TYPE_QA;
            flags     = frame_buf[POS_B2];
            lo        = frame_buf[POS_B3];
        end
        sum = 8'h00;
        for (k = 1; k < 8; k++)
            sum = sum + frame_buf[k];
        if (frame_buf[POS_TYPE] != want_type)
            r.status = ST_BAD_TYPE;
        else if (!warm_finished && seconds_seen < warm_limit)
            r.status = ST_WARMING;
        else
        begin
            warm_finished = 1'b1;
            if (frame_buf[POS_CHECK] != 8'(8'h00 - sum))
                r.status = ST_CHECKSUM;
            else if ((flags & FAULT_MASK) != 8'h00)
                r.status = ST_FAULT;
            else
            begin
                r.status = ST_OK;
                r.conc   = CONC_W'({flags & HIGH_MASK, lo});
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_pos      = POS_START;
            seconds_seen  = '0;
            warm_finished = 1'b0;
            stream_mode   = 1'b1;
            warm_limit    = '0;
            errors        = 0;
            readings_due.delete();
            mismatch_total      <= '0;
            results_outstanding <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE_SELECT:    stream_mode = cfg_data[0];
                    REG_WARMUP_SECONDS: warm_limit  = cfg_data[SEC_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                if (cmd == CMD_TICK)
                begin
                    if (seconds_seen != '1)
                        seconds_seen = seconds_seen + 1'b1;
                end
                else if (fill_pos != POS_START || rx_byte == START_BYTE)
                begin
                    frame_buf[fill_pos] = rx_byte;
                    if (fill_pos == POS_CHECK)
                    begin
                        fill_pos = POS_START;
                        readings_due.push_back(assess_frame());
                    end
                    else
                        fill_pos = fill_pos + 1'b1;
                end
            end

            if (out_valid && out_ready)
            begin
                if (readings_due.size() == 0)
                begin
                    $error("unexpected result: status %0d, concentration_tenths %0d",
                           status, concentration_tenths);
                    errors++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        errors++;
                    end
                    if (concentration_tenths !== want.conc)
                    begin
                        $error("concentration_tenths: expected %0d, actual %0d",
                               want.conc, concentration_tenths);
                        errors++;
                    end
                end
            end

            mismatch_total      <= errors;
            results_outstanding <= readings_due.size();
        end
    end

endmodule

@@ verif/tb_gas_sensor_frame_parser.sv @@
`timescale 1ns / 1ps

// Top level of the frame parser testbench. This module only makes stimulus
// and gives the verdict; the checker beside the block does all prediction.
module tb_gas_sensor_frame_parser;

    import gsfp_pkg::*;

    // The sorts of well-formed frame the stimulus can build.
    typedef enum logic [1:0] {
        KIND_GOOD,
        KIND_BAD_CHECK,
        KIND_FAULT,
        KIND_BAD_TYPE
    } frame_kind_t;

    // The receiver holds off for this long once during the pressure phase.
    localparam int HOLD_CYCLES = 300;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  cmd       = CMD_BYTE;
    logic [7:0]            rx_byte   = 8'h00;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [CONC_W-1:0]     concentration_tenths;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MODE_SELECT;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic [31:0]           mismatch_total;
    logic [31:0]           results_outstanding;

    // Stimulus-side bookkeeping. The testbench knows the mode it wrote, so it
    // can build frames of the right type. It also follows the frame slot and
    // the tick count, so that directed sequences can be lined up.
    logic [7:0] frame_out [FRAME_LEN];
    logic       tb_stream  = 1'b1;
    int         frame_slot = 0;
    int         ticks_sent = 0;
    int         items_sent = 0;
    logic       tx_eager   = 1'b0;
    logic       rx_eager   = 1'b0;
    logic       hold_req   = 1'b0;

    gas_sensor_frame_parser u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .cmd                  (cmd),
        .rx_byte              (rx_byte),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .status               (status),
        .concentration_tenths (concentration_tenths),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    gsfp_frame_checker u_checker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .cmd                  (cmd),
        .rx_byte              (rx_byte),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .status               (status),
        .concentration_tenths (concentration_tenths),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .mismatch_total       (mismatch_total),
        .results_outstanding  (results_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Safety net: a correct run finishes in a small fraction of this.
    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Offers one request on the input channel and returns at the clock edge
    // that accepts it. Valid is only lowered when an idle gap is drawn, so it
    // stays high across back-to-back requests.
    task automatic offer(input logic c, input logic [7:0] b);
        int unsigned gap;
        gap = tx_eager ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (c == CMD_TICK)
            ticks_sent++;
        else if (frame_slot != 0 || b == START_BYTE)
            frame_slot = (frame_slot == FRAME_LEN - 1) ? 0 : frame_slot + 1;
    endtask

    // Stops offering, waits until every queued reading has been delivered,
    // then lets the pipeline run empty in case the last request was a tick.
    // The first edge lets the checker's count catch up with the last request.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Registers are only written once the block has gone quiet.
    task automatic set_registers(input logic [CFG_W-1:0] mode_val,
                                 input logic [CFG_W-1:0] warm_val);
        settle();
        write_reg(REG_MODE_SELECT, mode_val);
        write_reg(REG_WARMUP_SECONDS, warm_val);
        cfg_we    <= 1'b0;
        tb_stream = mode_val[0];
    endtask

    // Builds a frame of the given sort for the mode currently in force.
    // Filler bytes are random and now and then a start byte, which the parser
    // must treat as plain data. One frame in eight carries the smallest or
    // the largest concentration.
    task automatic compose_frame(input frame_kind_t kind);
        logic [POS_W-1:0] hi_at;
        logic [POS_W-1:0] lo_at;
        logic [7:0]       want_type;
        logic [7:0]       sum;
        logic             rail;
        int               k;
        hi_at     = tb_stream ? POS_B4 : POS_B2;
        lo_at     = tb_stream ? POS_B5 : POS_B3;
        want_type = tb_stream ? TYPE_STREAM : TYPE_QA;
        frame_out[POS_START] = START_BYTE;
        for (k = 1; k < FRAME_LEN; k++)
            frame_out[k] = ($urandom_range(0, 15) == 0) ? START_BYTE : 8'($urandom);
        frame_out[POS_TYPE] = want_type;
        if ($urandom_range(0, 7) == 0)
        begin
            rail = $urandom_range(0, 1);
            frame_out[hi_at][4:0] = {5{rail}};
            frame_out[lo_at]      = {8{rail}};
        end
        frame_out[hi_at][7] = (kind == KIND_FAULT);
        if (kind == KIND_BAD_TYPE)
        begin
            // Half the time the type byte of the other mode, else anything.
            if ($urandom_range(0, 1) == 0)
                frame_out[POS_TYPE] = tb_stream ? TYPE_QA : TYPE_STREAM;
            else
            begin
                frame_out[POS_TYPE] = 8'($urandom);
                if (frame_out[POS_TYPE] == want_type)
                    frame_out[POS_TYPE] = want_type ^ 8'h01;
            end
        end
        sum = 8'h00;
        for (k = 1; k < 8; k++)
            sum = sum + frame_out[k];
        frame_out[POS_CHECK] = 8'h00 - sum;
        if (kind == KIND_BAD_CHECK)
            frame_out[POS_CHECK] = frame_out[POS_CHECK] ^ 8'($urandom_range(1, 255));
    endtask

    // Sends a whole frame. Ticks between its bytes are optional, since the
    // directed warm-up checks need the elapsed count to stay put.
    task automatic send_frame(input frame_kind_t kind, input logic with_ticks);
        int k;
        compose_frame(kind);
        for (k = 0; k < FRAME_LEN; k++)
        begin
            if (with_ticks && $urandom_range(0, 19) == 0)
                offer(CMD_TICK, 8'($urandom));
            offer(CMD_BYTE, frame_out[k]);
        end
    endtask

    // Brings the parser back to hunting for a start byte. Zero bytes complete
    // any frame in progress and are dropped once it is done.
    task automatic resync();
        while (frame_slot != 0)
            offer(CMD_BYTE, 8'h00);
    endtask

    // Mostly well-formed frames with random content. The rest is line noise,
    // ticks and frames cut short, which the parser then merges with what
    // follows.
    task automatic run_random(input int n);
        int          first;
        int unsigned roll;
        int unsigned len;
        int          k;
        frame_kind_t kind;
        first = items_sent;
        while (items_sent - first < n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                roll = $urandom_range(0, 9);
                if (roll < 4)
                    kind = KIND_GOOD;
                else if (roll < 6)
                    kind = KIND_BAD_CHECK;
                else if (roll < 8)
                    kind = KIND_FAULT;
                else
                    kind = KIND_BAD_TYPE;
                send_frame(kind, 1'b1);
            end
            else if (roll < 75)
                offer(CMD_BYTE, 8'($urandom));
            else if (roll < 90)
                offer(CMD_TICK, 8'($urandom));
            else
            begin
                len = $urandom_range(1, FRAME_LEN - 1);
                compose_frame(KIND_GOOD);
                for (k = 0; k < len; k++)
                    offer(CMD_BYTE, frame_out[k]);
            end
        end
    endtask

    // Result receiver. Its stall is drawn per result and starts when the
    // result shows up, so that it really holds the block's output. Once, on
    // request, it holds off for a long stretch to back the block up.
    initial
    begin : receiver
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else
            begin
                stall = rx_eager ? 0 : $urandom_range(0, 7);
                if (stall != 0)
                begin
                    out_ready <= 1'b0;
                    do
                        @(posedge clk);
                    while (!out_valid);
                    repeat (stall - 1) @(posedge clk);
                end
                out_ready <= 1'b1;
            end
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin : stimulus
        int         p;
        int         k;
        logic [15:0] warm_val;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening in stream mode with the longest warm-up. The upper
        // bits of the mode write must be ignored. Bytes before a start byte
        // are dropped, a wrongly typed frame reports its type, and a good one
        // reports warming.
        set_registers(16'hFFFF, 16'hFFFF);
        offer(CMD_BYTE, 8'h00);
        offer(CMD_BYTE, 8'h7E);
        offer(CMD_TICK, 8'hA5);
        send_frame(KIND_BAD_TYPE, 1'b0);
        send_frame(KIND_GOOD, 1'b0);

        // Question-answer mode, still warming up, with random traffic.
        set_registers(16'hFFFE, 16'hFFFF);
        run_random(200);

        // A wrongly typed frame arriving just as the warm-up time is reached
        // must not end the warm-up: once the limit is raised again, a good
        // frame still reports warming.
        resync();
        set_registers({15'($urandom), tb_stream}, 16'(ticks_sent));
        send_frame(KIND_BAD_TYPE, 1'b0);
        set_registers({15'($urandom), tb_stream}, 16'hFFFF);
        send_frame(KIND_GOOD, 1'b0);

        // Random phases through a spread of register settings, with the
        // extremes first. Both sides sometimes run without idling.
        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: set_registers(16'h0000, 16'h0000);
                1: set_registers(16'hFFFF, 16'hFFFF);
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       warm_val = 16'h0000;
                        1:       warm_val = 16'hFFFF;
                        default: warm_val = 16'($urandom);
                    endcase
                    set_registers(16'($urandom), warm_val);
                end
            endcase
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);

            if (p == 3)
            begin
                // The receiver stops for a long while as the sender keeps
                // pushing frames, so the queue fills and input is stalled.
                // The sender then waits for every reading to drain.
                hold_req = 1'b1;
                tx_eager = 1'b1;
                repeat (6) send_frame(KIND_GOOD, 1'b0);
                settle();
                tx_eager = 1'b0;
            end

            if (p == 5)
            begin
                // Flip the mode halfway through a frame. The mode in force at
                // the last byte decides the type byte and the field positions.
                resync();
                compose_frame(KIND_GOOD);
                for (k = 0; k < 5; k++)
                    offer(CMD_BYTE, frame_out[k]);
                settle();
                write_reg(REG_MODE_SELECT, {15'h0000, ~tb_stream});
                cfg_we <= 1'b0;
                tb_stream = ~tb_stream;
                compose_frame(KIND_GOOD);
                for (k = 5; k < FRAME_LEN; k++)
                    offer(CMD_BYTE, frame_out[k]);
            end

            run_random(190);
        end

        // Drain, allow for the pipeline depth, then give the verdict.
        settle();
        repeat (8) @(posedge clk);
        if (mismatch_total == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/gsfp_pkg.sv
rtl/gsfp_front.sv
rtl/gsfp_queue.sv
rtl/gsfp_back.sv
rtl/gas_sensor_frame_parser.sv
verif/gsfp_frame_checker.sv
verif/tb_gas_sensor_frame_parser.sv
